// ===== rtl/qspd_pkg.sv =====
`default_nettype none

package qspd_pkg;

    localparam logic [7:0] CHAR_AMP = 8'h26;
    localparam logic [7:0] CHAR_EQ  = 8'h3D;
    localparam logic [7:0] CHAR_PCT = 8'h25;

    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    localparam int MAX_RESULTS = 4;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_NAME  = 2'd1,
        MODE_VALUE = 2'd2,
        MODE_DROP  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } t_esc;

    typedef struct packed {
        logic [7:0] decoded;
        logic [1:0] kind;
        logic       query_done;
    } t_result;

    // all results caused by one input item; last_idx points at the final one
    typedef struct packed {
        logic [1:0]               last_idx;
        t_result [MAX_RESULTS-1:0] res;
    } t_bundle;

endpackage

`default_nettype wire

// ===== rtl/query_string_pair_decoder_core.sv =====
`default_nettype none

// Percent-decoding splitter for query strings: raw bytes go in one per cycle,
// decoded name bytes, value bytes and pair-end markers come out. A byte is
// accepted every cycle while full is low; each byte yields zero to four
// results, and the output register hands out one result per cycle while the
// consumer pops, so a byte with n results holds the output side for n pops.
// A two-entry queue of per-byte result groups between the classifier and the
// output serializer absorbs those bursts. A byte's first result is registered
// in the queue and then in the output register before it reaches the ports.
module query_string_pair_decoder_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push,
    output logic        o_full,
    input  wire  [7:0]  i_raw_byte,
    input  wire         i_final_byte,
    output logic        o_empty,
    input  wire         i_pop,
    output logic [7:0]  o_decoded,
    output logic [1:0]  o_kind,
    output logic        o_query_done,
    output logic        o_run_last
);

    logic              w_accept;
    logic              w_qpush, w_qvalid, w_qpop;
    qspd_pkg::t_bundle w_in_bundle, w_out_bundle;

    assign w_accept = i_push && !o_full;

    qspd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_raw_byte   (i_raw_byte),
        .i_final_byte (i_final_byte),
        .o_push       (w_qpush),
        .o_bundle     (w_in_bundle)
    );

    qspd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_qpush),
        .i_bundle (w_in_bundle),
        .o_full   (o_full),
        .o_valid  (w_qvalid),
        .o_bundle (w_out_bundle),
        .i_pop    (w_qpop)
    );

    qspd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_qvalid),
        .i_bundle     (w_out_bundle),
        .o_qpop       (w_qpop),
        .o_empty      (o_empty),
        .i_pop        (i_pop),
        .o_decoded    (o_decoded),
        .o_kind       (o_kind),
        .o_query_done (o_query_done),
        .o_run_last   (o_run_last)
    );

endmodule

`default_nettype wire

// ===== rtl/qspd_front.sv =====
`default_nettype none

module qspd_front (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_accept,
    input  wire  [7:0]              i_raw_byte,
    input  wire                     i_final_byte,
    output logic                    o_push,
    output qspd_pkg::t_bundle       o_bundle
);

    qspd_pkg::t_mode r_mode, n_mode, w_mode_mid;
    qspd_pkg::t_esc  r_esc, n_esc, w_esc_mid;
    logic [7:0]      r_held, n_held, w_held_mid;

    logic       w_amp, w_eq, w_pct, w_hex;
    logic       w_part, w_bnd_amp, w_bnd_eq;
    logic [3:0] w_nib_b, w_nib_h;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66)
              || (c >= 8'h41 && c <= 8'h46);
    endfunction

    // digits map through the low nibble, letters add ten above the 'a'/'A' base
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        hex_val = (c <= 8'h39) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    function automatic qspd_pkg::t_result mk(input logic [7:0] b, input logic [1:0] k,
                                             input logic d);
        qspd_pkg::t_result r;
        r.decoded    = b;
        r.kind       = k;
        r.query_done = d;
        mk = r;
    endfunction

    assign w_amp   = (i_raw_byte == qspd_pkg::CHAR_AMP);
    assign w_eq    = (i_raw_byte == qspd_pkg::CHAR_EQ);
    assign w_pct   = (i_raw_byte == qspd_pkg::CHAR_PCT);
    assign w_hex   = is_hex(i_raw_byte);
    assign w_nib_b = hex_val(i_raw_byte);
    assign w_nib_h = hex_val(r_held);

    assign w_bnd_amp = (r_mode == qspd_pkg::MODE_NAME || r_mode == qspd_pkg::MODE_VALUE) && w_amp;
    assign w_bnd_eq  = (r_mode == qspd_pkg::MODE_NAME) && w_eq;
    assign w_part    = ((r_mode == qspd_pkg::MODE_START) && !w_amp && !w_eq)
                    || ((r_mode == qspd_pkg::MODE_NAME) && !w_amp && !w_eq)
                    || ((r_mode == qspd_pkg::MODE_VALUE) && !w_amp);

    // next state
    always_comb begin
        w_mode_mid = r_mode;
        case (r_mode)
            qspd_pkg::MODE_START: begin
                if (w_eq) begin
                    w_mode_mid = qspd_pkg::MODE_DROP;
                end else if (!w_amp) begin
                    w_mode_mid = qspd_pkg::MODE_NAME;
                end
            end
            qspd_pkg::MODE_DROP: begin
                if (w_amp) w_mode_mid = qspd_pkg::MODE_START;
            end
            qspd_pkg::MODE_NAME: begin
                if (w_amp) begin
                    w_mode_mid = qspd_pkg::MODE_START;
                end else if (w_eq) begin
                    w_mode_mid = qspd_pkg::MODE_VALUE;
                end
            end
            qspd_pkg::MODE_VALUE: begin
                if (w_amp) w_mode_mid = qspd_pkg::MODE_START;
            end
            default: begin
                w_mode_mid = qspd_pkg::MODE_START;
            end
        endcase

        w_esc_mid  = r_esc;
        w_held_mid = r_held;
        if (w_bnd_amp || w_bnd_eq) begin
            w_esc_mid  = qspd_pkg::ESC_NONE;
            w_held_mid = 8'd0;
        end else if (w_part) begin
            if (r_esc == qspd_pkg::ESC_PCT && w_hex) begin
                w_esc_mid  = qspd_pkg::ESC_DIGIT;
                w_held_mid = i_raw_byte;
            end else begin
                w_esc_mid  = (w_pct && !(r_esc == qspd_pkg::ESC_DIGIT && w_hex))
                           ? qspd_pkg::ESC_PCT : qspd_pkg::ESC_NONE;
                w_held_mid = 8'd0;
            end
        end

        // the final byte returns everything to the reset values
        if (i_final_byte) begin
            n_mode = qspd_pkg::MODE_START;
            n_esc  = qspd_pkg::ESC_NONE;
            n_held = 8'd0;
        end else begin
            n_mode = w_mode_mid;
            n_esc  = w_esc_mid;
            n_held = w_held_mid;
        end
    end

    // results of this item
    always_comb begin
        qspd_pkg::t_result [qspd_pkg::MAX_RESULTS-1:0] v_res;
        logic [2:0] v_cnt;
        logic [1:0] v_kold, v_kmid;

        v_res  = '0;
        v_cnt  = 3'd0;
        v_kold = (r_mode == qspd_pkg::MODE_NAME) ? qspd_pkg::KIND_NAME : qspd_pkg::KIND_VALUE;
        v_kmid = (w_mode_mid == qspd_pkg::MODE_NAME) ? qspd_pkg::KIND_NAME
                                                      : qspd_pkg::KIND_VALUE;

        if (w_part) begin
            if (r_esc == qspd_pkg::ESC_PCT && w_hex) begin
                v_cnt = 3'd0;
            end else if (r_esc == qspd_pkg::ESC_DIGIT && w_hex) begin
                v_res[v_cnt[1:0]] = mk({w_nib_h, w_nib_b}, v_kmid, 1'b0);
                v_cnt = v_cnt + 3'd1;
            end else begin
                // escape cut short: emit the pending bytes literally
                if (r_esc != qspd_pkg::ESC_NONE) begin
                    v_res[v_cnt[1:0]] = mk(qspd_pkg::CHAR_PCT, v_kmid, 1'b0);
                    v_cnt = v_cnt + 3'd1;
                end
                if (r_esc == qspd_pkg::ESC_DIGIT) begin
                    v_res[v_cnt[1:0]] = mk(r_held, v_kmid, 1'b0);
                    v_cnt = v_cnt + 3'd1;
                end
                if (!w_pct) begin
                    v_res[v_cnt[1:0]] = mk(i_raw_byte, v_kmid, 1'b0);
                    v_cnt = v_cnt + 3'd1;
                end
            end
        end

        if (w_bnd_amp || w_bnd_eq) begin
            if (r_esc != qspd_pkg::ESC_NONE) begin
                v_res[v_cnt[1:0]] = mk(qspd_pkg::CHAR_PCT, v_kold, 1'b0);
                v_cnt = v_cnt + 3'd1;
            end
            if (r_esc == qspd_pkg::ESC_DIGIT) begin
                v_res[v_cnt[1:0]] = mk(r_held, v_kold, 1'b0);
                v_cnt = v_cnt + 3'd1;
            end
            if (w_bnd_amp) begin
                v_res[v_cnt[1:0]] = mk(8'd0, qspd_pkg::KIND_END, i_final_byte);
                v_cnt = v_cnt + 3'd1;
            end
        end

        // end of query closes an open pair
        if (i_final_byte && !w_bnd_amp
                && (w_mode_mid == qspd_pkg::MODE_NAME || w_mode_mid == qspd_pkg::MODE_VALUE)) begin
            if (w_esc_mid != qspd_pkg::ESC_NONE) begin
                v_res[v_cnt[1:0]] = mk(qspd_pkg::CHAR_PCT, v_kmid, 1'b0);
                v_cnt = v_cnt + 3'd1;
            end
            if (w_esc_mid == qspd_pkg::ESC_DIGIT) begin
                v_res[v_cnt[1:0]] = mk(w_held_mid, v_kmid, 1'b0);
                v_cnt = v_cnt + 3'd1;
            end
            v_res[v_cnt[1:0]] = mk(8'd0, qspd_pkg::KIND_END, 1'b1);
            v_cnt = v_cnt + 3'd1;
        end

        o_bundle.res      = v_res;
        o_bundle.last_idx = 2'(v_cnt - 3'd1);
        o_push            = i_accept && (v_cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= qspd_pkg::MODE_START;
            r_esc  <= qspd_pkg::ESC_NONE;
            r_held <= 8'd0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_held <= n_held;
        end
    end

    a_final_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_final_byte |=> r_mode == qspd_pkg::MODE_START && r_esc == qspd_pkg::ESC_NONE)
        else $error("state not cleared after final byte");

    a_drop_no_escape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == qspd_pkg::MODE_START || r_mode == qspd_pkg::MODE_DROP)
            |-> r_esc == qspd_pkg::ESC_NONE)
        else $error("escape pending outside a name or value");

endmodule

`default_nettype wire

// ===== rtl/qspd_queue.sv =====
`default_nettype none

module qspd_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  qspd_pkg::t_bundle       i_bundle,
    output logic                    o_full,
    output logic                    o_valid,
    output qspd_pkg::t_bundle       o_bundle,
    input  wire                     i_pop
);

    qspd_pkg::t_bundle r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;

    assign o_full   = (r_cnt == 2'd2);
    assign o_valid  = (r_cnt != 2'd0);
    assign o_bundle = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) n_cnt = r_cnt + 2'd1;
        if (!i_push && i_pop) n_cnt = r_cnt - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            r_cnt <= n_cnt;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/qspd_back.sv =====
`default_nettype none

module qspd_back (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    input  qspd_pkg::t_bundle       i_bundle,
    output logic                    o_qpop,
    output logic                    o_empty,
    input  wire                     i_pop,
    output logic [7:0]              o_decoded,
    output logic [1:0]              o_kind,
    output logic                    o_query_done,
    output logic                    o_run_last
);

    logic              r_out_valid;
    qspd_pkg::t_result r_out;
    logic              r_last;
    logic [1:0]        r_idx;
    logic              w_load, w_is_last;

    assign w_load    = i_valid && (!r_out_valid || i_pop);
    assign w_is_last = (r_idx == i_bundle.last_idx);
    assign o_qpop    = w_load && w_is_last;

    assign o_empty      = !r_out_valid;
    assign o_decoded    = r_out.decoded;
    assign o_kind       = r_out.kind;
    assign o_query_done = r_out.query_done;
    assign o_run_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out  <= i_bundle.res[r_idx];
            r_last <= w_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_idx       <= w_is_last ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> r_idx <= i_bundle.last_idx)
        else $error("serializer index past last result");

    a_idx_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> r_idx == 2'd0)
        else $error("serializer index left mid-bundle");

endmodule

`default_nettype wire
